// File: sv/quaternion_slerp_defines.svh
// Assertion macros shared by the slerp RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define QS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/qslerp_pkg.sv
// Shared constants, context type and rounding helper for the slerp pipeline.
// No dependencies.
package qslerp_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IBITS     = 30;
    localparam int RAD_W     = 61;   // radicand width of the square root chain
    localparam int ACC_W     = 62;   // working width of the root accumulator
    localparam int ROOT_W    = 31;
    localparam int SQ_STEPS  = 31;
    localparam int QUO_W     = 63;   // dividend / quotient width
    localparam int REM_W     = 31;
    localparam int WGT_W     = 48;

    localparam logic [31:0] ONE30 = 32'd1073741824;

    typedef struct packed {
        logic [3:0][16:0] q1;    // first quaternion after sign fix
        logic [3:0][15:0] q2;
        logic [14:0]      frac;
        logic [30:0]      c;     // clamped cosine, Q1.30
        logic [30:0]      s;     // sine, Q1.30
        logic             lin;   // linear weights selected
        logic [30:0]      hc;    // running half-angle cosine
        logic [31:0]      rc;    // rotation accumulator, signed
        logic [31:0]      rs;
        logic             na;    // sign of weight A numerator
        logic             nb;
    } t_ctx;

    // floor((x + 2^29) / 2^30)
    function automatic logic signed [35:0] f_round30(input logic signed [65:0] x);
        logic signed [65:0] y;
        y = x + 66'sd536870912;
        return 36'(y >>> IBITS);
    endfunction

endpackage

// File: sv/qslerp_sqrt.sv
// Chain of integer square root cells, one result bit per cell, 1..2 lanes.
// Depends on qslerp_pkg.
module qslerp_sqrt
    import qslerp_pkg::*;
#(
    parameter int LANES = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  t_ctx                           i_ctx,
    input  logic [LANES-1:0][RAD_W-1:0]    i_rad,
    output logic                           o_vld,
    output t_ctx                           o_ctx,
    output logic [LANES-1:0][ROOT_W-1:0]   o_root
);

    logic [LANES-1:0][RAD_W-1:0] r_v   [SQ_STEPS];
    logic [LANES-1:0][ACC_W-1:0] r_r   [SQ_STEPS];
    t_ctx                        r_ctx [SQ_STEPS];
    logic                        r_vld [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
        localparam logic [ACC_W-1:0] BIT = {{(ACC_W-1){1'b0}}, 1'b1} << (RAD_W - 1 - 2*i);

        logic [LANES-1:0][RAD_W-1:0] w_v_in, n_v;
        logic [LANES-1:0][ACC_W-1:0] w_r_in, n_r, w_sum;
        t_ctx                        w_ctx_in;
        logic                        w_vld_in;

        if (i == 0) begin : g_first
            assign w_v_in   = i_rad;
            assign w_r_in   = '0;
            assign w_ctx_in = i_ctx;
            assign w_vld_in = i_vld;
        end else begin : g_next
            assign w_v_in   = r_v[i-1];
            assign w_r_in   = r_r[i-1];
            assign w_ctx_in = r_ctx[i-1];
            assign w_vld_in = r_vld[i-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_sum[l] = w_r_in[l] + BIT;
                if ({1'b0, w_v_in[l]} >= w_sum[l]) begin
                    n_v[l] = RAD_W'({1'b0, w_v_in[l]} - w_sum[l]);
                    n_r[l] = (w_r_in[l] >> 1) + BIT;
                end else begin
                    n_v[l] = w_v_in[l];
                    n_r[l] = w_r_in[l] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[i]   <= n_v;
                r_r[i]   <= n_r;
                r_ctx[i] <= w_ctx_in;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_r[SQ_STEPS-1][l][ROOT_W-1:0];
        end
    end

    assign o_vld = r_vld[SQ_STEPS-1];
    assign o_ctx = r_ctx[SQ_STEPS-1];

endmodule

// File: sv/qslerp_rot.sv
// Two-stage rotation multiply: (rc,rs) times (mc,ms) when apply is set.
// Depends on qslerp_pkg.
module qslerp_rot
    import qslerp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_ctx              i_ctx,
    input  logic              i_apply,
    input  logic [ROOT_W-1:0] i_mc,
    input  logic [ROOT_W-1:0] i_ms,
    output logic              o_vld,
    output t_ctx              o_ctx
);

    logic signed [63:0] r_pcc, r_pss, r_psc, r_pcs;
    logic               r_apply;
    logic               r_vld1;
    t_ctx               r_ctx1;
    logic               r_vld2;
    t_ctx               r_ctx2;
    t_ctx               n_ctx2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pcc   <= $signed(i_ctx.rc) * $signed({1'b0, i_mc});
            r_pss   <= $signed(i_ctx.rs) * $signed({1'b0, i_ms});
            r_psc   <= $signed(i_ctx.rs) * $signed({1'b0, i_mc});
            r_pcs   <= $signed(i_ctx.rc) * $signed({1'b0, i_ms});
            r_apply <= i_apply;
            r_ctx1  <= i_ctx;
            r_ctx2  <= n_ctx2;
        end
    end

    always_comb begin
        n_ctx2 = r_ctx1;
        if (r_apply) begin
            n_ctx2.rc = 32'(f_round30(66'(r_pcc) - 66'(r_pss)));
            n_ctx2.rs = 32'(f_round30(66'(r_psc) + 66'(r_pcs)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;
    assign o_ctx = r_ctx2;

endmodule

// File: sv/qslerp_div.sv
// Chain of restoring divider cells, one quotient bit per cell; lanes share
// the divisor ctx.s. Depends on qslerp_pkg.
module qslerp_div
    import qslerp_pkg::*;
#(
    parameter int LANES = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  t_ctx                         i_ctx,
    input  logic [LANES-1:0][QUO_W-1:0]  i_num,
    output logic                         o_vld,
    output t_ctx                         o_ctx,
    output logic [LANES-1:0][QUO_W-1:0]  o_quo
);

    logic [LANES-1:0][QUO_W-1:0] r_q   [QUO_W];
    logic [LANES-1:0][REM_W-1:0] r_rem [QUO_W];
    t_ctx                        r_ctx [QUO_W];
    logic                        r_vld [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        logic [LANES-1:0][QUO_W-1:0] w_q_in, n_q;
        logic [LANES-1:0][REM_W-1:0] w_rem_in, n_rem;
        logic [LANES-1:0][REM_W:0]   w_ext;
        logic [REM_W:0]              w_den;
        t_ctx                        w_ctx_in;
        logic                        w_vld_in;

        if (i == 0) begin : g_first
            assign w_q_in   = i_num;
            assign w_rem_in = '0;
            assign w_ctx_in = i_ctx;
            assign w_vld_in = i_vld;
        end else begin : g_next
            assign w_q_in   = r_q[i-1];
            assign w_rem_in = r_rem[i-1];
            assign w_ctx_in = r_ctx[i-1];
            assign w_vld_in = r_vld[i-1];
        end

        assign w_den = {1'b0, w_ctx_in.s};

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_ext[l] = {w_rem_in[l], w_q_in[l][QUO_W-1]};
                if (w_ext[l] >= w_den) begin
                    n_rem[l] = REM_W'(w_ext[l] - w_den);
                    n_q[l]   = {w_q_in[l][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_ext[l][REM_W-1:0];
                    n_q[l]   = {w_q_in[l][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i]   <= n_q;
                r_rem[i] <= n_rem;
                r_ctx[i] <= w_ctx_in;
            end
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_ctx = r_ctx[QUO_W-1];
    assign o_quo = r_q[QUO_W-1];

endmodule

// File: sv/quaternion_slerp.sv
// Top level of the quaternion slerp pipeline with its APB register.
// Depends on qslerp_pkg, qslerp_sqrt, qslerp_rot, qslerp_div and the defines header.
//
// Usage:
//   s_axis carries one request per beat: two Q2.14 quaternions and a Q.14
//   fraction t. m_axis returns the interpolated quaternion, rounded and
//   saturated to +-1.0. Every request yields exactly one result, in order.
//   One request is taken every cycle while the chain is not stalled. The chain has
//   4 front stages and 31 square root cells for the sine, the small-sine stage,
//   14 half-angle segments of a radicand register, 31 cells and a two-stage
//   rotation multiply, the whole-number rotation, the numerator stages, 63
//   divider cells and 3 output stages. All stages advance together; when
//   m_axis holds a result that is not taken, the whole chain and
//   s_axis_tready stall until it is. Reset (synchronous, active low) clears
//   every stage valid and sets the small-sine threshold to 2. The user must
//   write the threshold through APB at byte address 0 only while no request
//   is in flight; the block itself does not enforce this.
`include "quaternion_slerp_defines.svh"

module quaternion_slerp
    import qslerp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // from low bit: first_s, first_x, first_y, first_z, second_s, second_x,
    // second_y, second_z, fraction, one pad bit
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    // from low bit: out_s, out_x, out_y, out_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata
);

    localparam logic [62:0] WCLAMP = 63'd70368744177664;   // 2^46
    localparam logic signed [35:0] LIM_POS = 36'sd16384;
    localparam logic signed [35:0] LIM_NEG = -36'sd16384;

    // Small-sine threshold register
    logic [14:0] r_thr;
    logic        w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {17'd0, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 15'd2;
        end else if (w_cfg_wr) begin
            r_thr <= pwdata[14:0];
        end
    end

    // Global advance: the chain moves when the output register is empty or its result is taken.
    logic w_adv;
    logic w_acc;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;

    // Stage 1: component products for the dot product
    logic               r1_vld;
    t_ctx               r1_ctx;
    t_ctx               n1_ctx;
    logic signed [31:0] r1_p [4];

    always_comb begin
        n1_ctx = '0;
        for (int i = 0; i < 4; i++) begin
            n1_ctx.q1[i] = {s_axis_tdata[16*i+15], s_axis_tdata[16*i +: 16]};
            n1_ctx.q2[i] = s_axis_tdata[64 + 16*i +: 16];
        end
        n1_ctx.frac = s_axis_tdata[142:128];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ctx <= n1_ctx;
            for (int i = 0; i < 4; i++) begin
                r1_p[i] <= $signed(s_axis_tdata[16*i +: 16])
                         * $signed(s_axis_tdata[64 + 16*i +: 16]);
            end
        end
    end

    // Stage 2: sum, shorter-arc sign fix, clamp to 1.0, move to Q1.30
    logic               r2_vld;
    t_ctx               r2_ctx;
    t_ctx               n2_ctx;
    logic signed [33:0] w_dot;
    logic [33:0]        w_dmag;

    always_comb begin
        w_dot  = 34'(r1_p[0]) + 34'(r1_p[1]) + 34'(r1_p[2]) + 34'(r1_p[3]);
        n2_ctx = r1_ctx;
        w_dmag = w_dot[33] ? 34'(-w_dot) : w_dot;
        if (w_dot[33]) begin
            for (int i = 0; i < 4; i++) begin
                n2_ctx.q1[i] = 17'(-$signed(r1_ctx.q1[i]));
            end
        end
        if (w_dmag > 34'd268435456) begin
            w_dmag = 34'd268435456;
        end
        n2_ctx.c = {w_dmag[28:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ctx <= n2_ctx;
        end
    end

    // Stage 3: c squared
    logic        r3_vld;
    t_ctx        r3_ctx;
    logic [61:0] r3_csq;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_ctx <= r2_ctx;
            r3_csq <= r2_ctx.c * r2_ctx.c;
        end
    end

    // Stage 4: radicand of the sine
    logic                       r4_vld;
    t_ctx                       r4_ctx;
    logic [0:0][RAD_W-1:0]      r4_rad;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_ctx    <= r3_ctx;
            r4_rad[0] <= RAD_W'((62'd1 << 60) - r3_csq);
        end
    end

    logic                   w_sin_vld;
    t_ctx                   w_sin_ctx;
    logic [0:0][ROOT_W-1:0] w_sin_root;

    qslerp_sqrt #(.LANES(1)) u_sin (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_vld  (r4_vld),
        .i_ctx  (r4_ctx),
        .i_rad  (r4_rad),
        .o_vld  (w_sin_vld),
        .o_ctx  (w_sin_ctx),
        .o_root (w_sin_root)
    );

    // Stage 5: small-sine decision, rotation starts at identity
    logic r5_vld;
    t_ctx r5_ctx;
    t_ctx n5_ctx;

    always_comb begin
        n5_ctx     = w_sin_ctx;
        n5_ctx.s   = w_sin_root[0];
        n5_ctx.lin = (w_sin_root[0] == '0) || (w_sin_root[0] < {r_thr, 16'd0});
        n5_ctx.hc  = w_sin_ctx.c;
        n5_ctx.rc  = ONE30;
        n5_ctx.rs  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_ctx <= n5_ctx;
        end
    end

    // Half-angle segments: each halves the angle with two roots and folds in
    // one fraction bit, most significant first.
    t_ctx w_seg_ctx [FRAC_BITS+1];
    logic w_seg_vld [FRAC_BITS+1];

    assign w_seg_ctx[0] = r5_ctx;
    assign w_seg_vld[0] = r5_vld;

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_seg
        logic                   r_pvld;
        t_ctx                   r_pctx;
        logic [1:0][RAD_W-1:0]  r_prad;
        logic                   w_svld;
        t_ctx                   w_sctx;
        t_ctx                   w_rctx;
        logic [1:0][ROOT_W-1:0] w_root;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pvld <= 1'b0;
            end else if (w_adv) begin
                r_pvld <= w_seg_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pctx    <= w_seg_ctx[k-1];
                r_prad[0] <= {ONE30 + {1'b0, w_seg_ctx[k-1].hc}, 29'd0};
                r_prad[1] <= {ONE30 - {1'b0, w_seg_ctx[k-1].hc}, 29'd0};
            end
        end

        qslerp_sqrt #(.LANES(2)) u_half (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_vld  (r_pvld),
            .i_ctx  (r_pctx),
            .i_rad  (r_prad),
            .o_vld  (w_svld),
            .o_ctx  (w_sctx),
            .o_root (w_root)
        );

        always_comb begin
            w_rctx    = w_sctx;
            w_rctx.hc = w_root[0];
        end

        qslerp_rot u_rot (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_vld  (w_svld),
            .i_ctx  (w_rctx),
            .i_apply(w_sctx.frac[FRAC_BITS-k]),
            .i_mc   (w_root[0]),
            .i_ms   (w_root[1]),
            .o_vld  (w_seg_vld[k]),
            .o_ctx  (w_seg_ctx[k])
        );
    end

    // Whole-number bit of the fraction rotates by the full angle
    logic w_whl_vld;
    t_ctx w_whl_ctx;

    qslerp_rot u_whole (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_vld  (w_seg_vld[FRAC_BITS]),
        .i_ctx  (w_seg_ctx[FRAC_BITS]),
        .i_apply(w_seg_ctx[FRAC_BITS].frac[FRAC_BITS]),
        .i_mc   (w_seg_ctx[FRAC_BITS].c),
        .i_ms   (w_seg_ctx[FRAC_BITS].s),
        .o_vld  (w_whl_vld),
        .o_ctx  (w_whl_ctx)
    );

    // Stage 6: numerator products of weight A
    logic               r6_vld;
    t_ctx               r6_ctx;
    logic signed [63:0] r6_p1, r6_p2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_ctx <= w_whl_ctx;
            r6_p1  <= $signed({1'b0, w_whl_ctx.s}) * $signed(w_whl_ctx.rc);
            r6_p2  <= $signed({1'b0, w_whl_ctx.c}) * $signed(w_whl_ctx.rs);
        end
    end

    // Stage 7: sign and magnitude of both numerators
    logic                   r7_vld;
    t_ctx                   r7_ctx;
    t_ctx                   n7_ctx;
    logic [1:0][QUO_W-1:0]  r7_num;
    logic [1:0][QUO_W-1:0]  n7_num;
    logic signed [63:0]     w_numa;
    logic [31:0]            w_rsmag;

    always_comb begin
        w_numa    = r6_p1 - r6_p2;
        n7_ctx    = r6_ctx;
        n7_ctx.na = w_numa[63];
        n7_ctx.nb = r6_ctx.rs[31];
        n7_num[0] = w_numa[63] ? QUO_W'(-w_numa) : QUO_W'(w_numa);
        w_rsmag   = r6_ctx.rs[31] ? 32'(-$signed(r6_ctx.rs)) : r6_ctx.rs;
        n7_num[1] = {1'b0, w_rsmag, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_ctx <= n7_ctx;
            r7_num <= n7_num;
        end
    end

    logic                  w_div_vld;
    t_ctx                  w_div_ctx;
    logic [1:0][QUO_W-1:0] w_quo;

    qslerp_div #(.LANES(2)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_vld  (r7_vld),
        .i_ctx  (r7_ctx),
        .i_num  (r7_num),
        .o_vld  (w_div_vld),
        .o_ctx  (w_div_ctx),
        .o_quo  (w_quo)
    );

    // Stage 8: clamp and sign the weights, or take the linear pair
    logic                    r8_vld;
    t_ctx                    r8_ctx;
    logic                    r8_lin;
    logic signed [WGT_W-1:0] r8_a, r8_b;
    logic signed [WGT_W-1:0] n8_a, n8_b;
    logic [QUO_W-1:0]        w_qa, w_qb;
    logic [WGT_W-1:0]        w_t30;

    always_comb begin
        w_qa  = (w_quo[0] > WCLAMP) ? WCLAMP : w_quo[0];
        w_qb  = (w_quo[1] > WCLAMP) ? WCLAMP : w_quo[1];
        w_t30 = {17'd0, w_div_ctx.frac, 16'd0};
        if (w_div_ctx.lin) begin
            n8_a = $signed({16'd0, ONE30}) - $signed(w_t30);
            n8_b = $signed(w_t30);
        end else begin
            n8_a = w_div_ctx.na ? -$signed(w_qa[WGT_W-1:0]) : $signed(w_qa[WGT_W-1:0]);
            n8_b = w_div_ctx.nb ? -$signed(w_qb[WGT_W-1:0]) : $signed(w_qb[WGT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_ctx <= w_div_ctx;
            r8_lin <= w_div_ctx.lin;
            r8_a   <= n8_a;
            r8_b   <= n8_b;
        end
    end

    // Stage 9: weighted components
    logic               r9_vld;
    logic signed [64:0] r9_pa [4];
    logic signed [63:0] r9_pb [4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r9_pa[i] <= $signed(r8_ctx.q1[i]) * r8_a;
                r9_pb[i] <= $signed(r8_ctx.q2[i]) * r8_b;
            end
        end
    end

    // Stage 10: sum, round, saturate into the output register
    logic               r10_vld;
    logic [3:0][15:0]   r10_out;
    logic [3:0][15:0]   n10_out;
    logic signed [35:0] w_res [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_res[i] = f_round30(66'(r9_pa[i]) + 66'(r9_pb[i]));
            if (w_res[i] > LIM_POS) begin
                n10_out[i] = 16'(LIM_POS);
            end else if (w_res[i] < LIM_NEG) begin
                n10_out[i] = 16'(LIM_NEG);
            end else begin
                n10_out[i] = w_res[i][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_out <= n10_out;
        end
    end

    // Valid chain of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld  <= w_acc;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= w_sin_vld;
            r6_vld  <= w_whl_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= w_div_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
        end
    end

    assign m_axis_tvalid = r10_vld;
    assign m_axis_tdata  = r10_out;

    logic w_out_ok;
    always_comb begin
        w_out_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if ($signed(r10_out[i]) > 16'sd16384 || $signed(r10_out[i]) < -16'sd16384) begin
                w_out_ok = 1'b0;
            end
        end
    end

    `QS_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, w_cfg_wr, r_thr == $past(pwdata[14:0]), "threshold write lost")
    `QS_ASSERT_IMP(a_lin_sum, i_clk, i_rst_n, r8_vld && r8_lin, (r8_a + r8_b) == $signed({16'd0, ONE30}), "linear weights do not sum to one")
    `QS_ASSERT_IMP(a_out_sat, i_clk, i_rst_n, m_axis_tvalid, w_out_ok, "result outside +-1.0")

endmodule
